// ===== rtl/mwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mwbs_pkg
// Shared types and constants for the maze wall bitmap store.
// ----------------------------------------------------------------------------
package mwbs_pkg;

  // side of a cell named by a request
  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int        DIM_W     = 5;
  localparam logic [4:0] DIM_RESET = 5'd16;

  // queue depths
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 3;
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // classified request handed from the front to the back
  typedef struct packed {
    logic write;  // write request, no result
    logic vert;   // vertical wall store
    logic oob;    // on or beyond the border
    logic value;  // write data
  } cmd_ctl_t;

endpackage

// ===== rtl/maze_wall_bitmap_store_core.sv =====
// ----------------------------------------------------------------------------
// maze_wall_bitmap_store_core
// Maze wall map: horizontal and vertical inner wall bits, read and written
// by cell and side, with border and outside walls reading as present.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while full is low, and a read result
// appears on the result side after passing the request queue, the RAM read
// register and the result queue; writes give no result. A front stage holds
// the dimensions and computes the wall index (one small multiply), a
// two-entry queue parts it from the back, which does one RAM access per cycle
// and keeps a three-entry result queue, so the block keeps its one-per-cycle
// rate while results drain. After reset full stays high while both stores
// are swept to zero; dimension writes are taken during that time.
module maze_wall_bitmap_store_core #(
  parameter int MAX_DIM = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  logic [7:0] cell_x,
  input  logic [7:0] cell_y,
  input  logic [1:0] direction,
  input  logic       wall_value,
  output logic       empty,
  input  logic       pop,
  output logic       wall_present
);

  localparam int WALL_BITS = MAX_DIM * (MAX_DIM - 1);
  localparam int IDX_W     = $clog2(WALL_BITS);
  localparam int CMD_W     = $bits(mwbs_pkg::cmd_ctl_t) + IDX_W;
  localparam int CMD_CNT_W = $clog2(mwbs_pkg::CMD_DEPTH + 1);

  mwbs_pkg::cmd_ctl_t in_ctl;
  mwbs_pkg::cmd_ctl_t out_ctl;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   out_idx;
  logic [CMD_W-1:0]   cmd_rd;
  logic               cmd_push;
  logic               cmd_full;
  logic               cmd_empty;
  logic               cmd_pop;
  logic [CMD_CNT_W-1:0] cmd_count;
  logic               clearing;
  logic               blocked;

  assign blocked = cmd_full || clearing;

  mwbs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .direction  (direction),
    .wall_value (wall_value),
    .blocked    (blocked),
    .cmd_push   (cmd_push),
    .cmd_ctl    (in_ctl),
    .cmd_idx    (in_idx)
  );

  mwbs_fifo #(.WIDTH(CMD_W), .DEPTH(mwbs_pkg::CMD_DEPTH)) u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data ({in_ctl, in_idx}),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign {out_ctl, out_idx} = cmd_rd;

  mwbs_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_empty    (cmd_empty),
    .cmd_ctl      (out_ctl),
    .cmd_idx      (out_idx),
    .cmd_pop      (cmd_pop),
    .clearing     (clearing),
    .pop          (pop),
    .empty        (empty),
    .wall_present (wall_present)
  );

`ifndef SYNTHESIS
  a_full_cmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_count == CMD_CNT_W'(mwbs_pkg::CMD_DEPTH)) |-> full)
    else $error("request queue full but input open");

  a_full_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full)
    else $error("input open during clearing pass");

  a_push_gate: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (push && !full))
    else $error("request queued without an accepted push");
`endif

endmodule

// ===== rtl/mwbs_ram.sv =====
// ----------------------------------------------------------------------------
// mwbs_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mwbs_ram #(
  parameter  int WIDTH  = 1,
  parameter  int DEPTH  = 240,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/mwbs_fifo.sv =====
// ----------------------------------------------------------------------------
// mwbs_fifo
// Small register queue with full, empty and fill count.
// ----------------------------------------------------------------------------
module mwbs_fifo #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             wr_fire;
  logic             rd_fire;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign wr_fire = wr_en && !full;
  assign rd_fire = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fifo count above depth");
`endif

endmodule

// ===== rtl/mwbs_front.sv =====
// ----------------------------------------------------------------------------
// mwbs_front
// Holds the maze dimensions, takes requests and classifies them: picks the
// wall store, computes the bit index and flags border or outside walls.
// ----------------------------------------------------------------------------
module mwbs_front #(
  parameter  int MAX_DIM   = 16,
  localparam int WALL_BITS = MAX_DIM * (MAX_DIM - 1),
  localparam int IDX_W     = $clog2(WALL_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic                 mode,
  input  logic [7:0]           cell_x,
  input  logic [7:0]           cell_y,
  input  logic [1:0]           direction,
  input  logic                 wall_value,
  input  logic                 blocked,
  output logic                 cmd_push,
  output mwbs_pkg::cmd_ctl_t   cmd_ctl,
  output logic [IDX_W-1:0]     cmd_idx
);

  localparam int         SUM_W   = (IDX_W > 11) ? IDX_W : 11;
  localparam logic [4:0] DIM_CAP = 5'((MAX_DIM > 31) ? 31 : MAX_DIM);

  logic [4:0]       maze_width;
  logic [4:0]       maze_height;
  logic [4:0]       w_eff;
  logic [4:0]       h_eff;
  logic [8:0]       x_adj;
  logic [8:0]       y_adj;
  logic [8:0]       major;
  logic [8:0]       minor;
  logic [4:0]       major_lim;
  logic [4:0]       minor_lim;
  logic [4:0]       minor_m1;
  logic [9:0]       prod;
  logic [SUM_W-1:0] slot;
  logic             vert;

  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= mwbs_pkg::DIM_RESET;
      maze_height <= mwbs_pkg::DIM_RESET;
    end else if (cfg_write) begin
      if (cfg_index == mwbs_pkg::REG_WIDTH) begin
        maze_width <= cfg_data;
      end else begin
        maze_height <= cfg_data;
      end
    end
  end

  assign w_eff = (maze_width  > DIM_CAP) ? DIM_CAP : maze_width;
  assign h_eff = (maze_height > DIM_CAP) ? DIM_CAP : maze_height;

  // one extra bit so a step east or north never wraps
  assign x_adj = {1'b0, cell_x}
               + 9'(mwbs_pkg::dir_t'(direction) == mwbs_pkg::DIR_EAST);
  assign y_adj = {1'b0, cell_y}
               + 9'(mwbs_pkg::dir_t'(direction) == mwbs_pkg::DIR_NORTH);

  always_comb begin
    unique case (mwbs_pkg::dir_t'(direction))
      mwbs_pkg::DIR_NORTH, mwbs_pkg::DIR_SOUTH: begin
        vert      = 1'b0;
        major     = x_adj;
        major_lim = w_eff;
        minor     = y_adj;
        minor_lim = h_eff;
      end
      default: begin
        vert      = 1'b1;
        major     = y_adj;
        major_lim = h_eff;
        minor     = x_adj;
        minor_lim = w_eff;
      end
    endcase
  end

  // minor_m1 wraps for a zero size, but that case is flagged out of bounds
  assign minor_m1 = minor_lim - 1'b1;
  assign prod     = major[4:0] * minor_m1;
  assign slot     = SUM_W'(prod) + SUM_W'(minor[4:0]) - 1'b1;

  assign full     = blocked;
  assign cmd_push = push && !blocked;

  always_comb begin
    cmd_ctl.write = (mode == mwbs_pkg::MODE_WRITE);
    cmd_ctl.vert  = vert;
    cmd_ctl.value = wall_value;
    cmd_ctl.oob   = (minor == '0)
                 || (minor >= {4'b0, minor_lim})
                 || (major >= {4'b0, major_lim})
                 || (slot >= SUM_W'(WALL_BITS));
    cmd_idx       = slot[IDX_W-1:0];
  end

endmodule

// ===== rtl/mwbs_back.sv =====
// ----------------------------------------------------------------------------
// mwbs_back
// Carries out classified requests against the two wall stores and queues
// read results. Sweeps both stores to zero after reset.
// ----------------------------------------------------------------------------
module mwbs_back #(
  parameter  int MAX_DIM   = 16,
  localparam int WALL_BITS = MAX_DIM * (MAX_DIM - 1),
  localparam int IDX_W     = $clog2(WALL_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_empty,
  input  mwbs_pkg::cmd_ctl_t cmd_ctl,
  input  logic [IDX_W-1:0]   cmd_idx,
  output logic               cmd_pop,
  output logic               clearing,
  input  logic               pop,
  output logic               empty,
  output logic               wall_present
);

  localparam int CW = mwbs_pkg::RES_CNT_W;

  logic [IDX_W-1:0] clr_addr;
  logic             inflight;
  logic             inf_oob;
  logic             inf_vert;
  logic             read_ok;
  logic             h_we;
  logic             v_we;
  logic [IDX_W-1:0] ram_addr;
  logic             ram_wdata;
  logic             h_rdata;
  logic             v_rdata;
  logic             res_data;
  logic             res_full;
  logic [CW-1:0]    res_count;

  // keep room in the result queue for the read in flight
  assign read_ok = ((CW+1)'(res_count) + (CW+1)'(inflight))
                   < (CW+1)'(mwbs_pkg::RES_DEPTH);
  assign cmd_pop = !cmd_empty && !clearing && (cmd_ctl.write || read_ok);

  assign ram_addr  = clearing ? clr_addr : cmd_idx;
  assign ram_wdata = clearing ? 1'b0 : cmd_ctl.value;
  assign h_we = clearing || (cmd_pop && cmd_ctl.write && !cmd_ctl.oob && !cmd_ctl.vert);
  assign v_we = clearing || (cmd_pop && cmd_ctl.write && !cmd_ctl.oob &&  cmd_ctl.vert);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      inflight <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == IDX_W'(WALL_BITS - 1)) begin
          clearing <= 1'b0;
        end
      end
      inflight <= cmd_pop && !cmd_ctl.write;
    end
  end

  always_ff @(posedge clk) begin
    inf_oob  <= cmd_ctl.oob;
    inf_vert <= cmd_ctl.vert;
  end

  mwbs_ram #(.WIDTH(1), .DEPTH(WALL_BITS)) u_h_ram (
    .clk   (clk),
    .we    (h_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (h_rdata)
  );

  mwbs_ram #(.WIDTH(1), .DEPTH(WALL_BITS)) u_v_ram (
    .clk   (clk),
    .we    (v_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (v_rdata)
  );

  assign res_data = inf_oob ? 1'b1 : (inf_vert ? v_rdata : h_rdata);

  mwbs_fifo #(.WIDTH(1), .DEPTH(mwbs_pkg::RES_DEPTH)) u_res_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (inflight),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (wall_present),
    .empty   (empty),
    .count   (res_count)
  );

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    inflight |-> !res_full)
    else $error("read result with no room in result queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop)
    else $error("request taken during clearing pass");

  a_inflight_src: assert property (@(posedge clk) disable iff (rst)
    inflight |-> $past(cmd_pop && !cmd_ctl.write))
    else $error("read in flight without a read request");
`endif

endmodule

// ===== test/tb_maze_wall_bitmap_store_core.sv =====
// ----------------------------------------------------------------------------
// tb_maze_wall_bitmap_store_core
// Self-checking bench for the maze wall map. Read and write requests go in
// through the push/full side and wall bits come back through the pop/empty
// side. A scoreboard keeps its own copy of both wall stores and the maze
// dimensions and checks every returned bit in order. A short directed set is
// followed by random phases over several maze shapes, zero and oversize among
// them, with random idle cycles on both sides in all phases but one.
// ----------------------------------------------------------------------------
module tb_maze_wall_bitmap_store_core;

  localparam int MAX_DIM      = 16;
  localparam int WALL_BITS    = MAX_DIM * (MAX_DIM - 1);
  localparam int N_SHAPES     = 8;
  localparam int PHASE_ITEMS  = 75;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 3000;  // covers the clearing sweep after reset
  localparam int SHAPE_W [N_SHAPES] = '{16, 1, 0, 31, 16, 2, 5, 17};
  localparam int SHAPE_H [N_SHAPES] = '{16, 1, 9, 31, 0, 16, 3, 12};

  typedef struct {
    logic           mode;
    logic [7:0]     x;
    logic [7:0]     y;
    mwbs_pkg::dir_t dir;
    logic           value;
  } wall_req_t;

  typedef struct {
    logic      wall;
    wall_req_t req;
  } wall_expect_t;

  class wall_map_checker;
    bit           horiz_walls[WALL_BITS];
    bit           vert_walls[WALL_BITS];
    logic [4:0]   width_reg;
    logic [4:0]   height_reg;
    wall_expect_t expected_walls[$];
    int           errors;
    int           reads_checked;
    int           writes_seen;

    function new();
      width_reg     = mwbs_pkg::DIM_RESET;
      height_reg    = mwbs_pkg::DIM_RESET;
      errors        = 0;
      reads_checked = 0;
      writes_seen   = 0;
    endfunction

    function void set_dim(logic idx, logic [4:0] val);
      if (idx == mwbs_pkg::REG_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // bit number of a wall, or -1 when it lies on or past the border
    function int slot_of(int major, int major_lim, int minor, int minor_lim);
      int idx;
      if (minor == 0 || minor >= minor_lim || major >= major_lim) return -1;
      idx = major * (minor_lim - 1) + (minor - 1);
      if (idx >= WALL_BITS) return -1;
      return idx;
    endfunction

    function void note_request(wall_req_t r);
      int           w;
      int           h;
      int           x;
      int           y;
      int           slot;
      bit           vert;
      wall_expect_t e;
      w = (width_reg > MAX_DIM) ? MAX_DIM : int'(width_reg);
      h = (height_reg > MAX_DIM) ? MAX_DIM : int'(height_reg);
      x = int'(r.x);
      y = int'(r.y);
      if (r.dir == mwbs_pkg::DIR_EAST) x++;
      if (r.dir == mwbs_pkg::DIR_NORTH) y++;
      vert = (r.dir == mwbs_pkg::DIR_EAST || r.dir == mwbs_pkg::DIR_WEST);
      slot = vert ? slot_of(y, h, x, w) : slot_of(x, w, y, h);
      if (r.mode == mwbs_pkg::MODE_WRITE) begin
        writes_seen++;
        if (slot >= 0) begin
          if (vert) vert_walls[slot] = r.value;
          else horiz_walls[slot] = r.value;
        end
      end else begin
        e.req  = r;
        e.wall = (slot < 0) ? 1'b1 : (vert ? vert_walls[slot] : horiz_walls[slot]);
        expected_walls.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_wall(logic got);
      wall_expect_t e;
      if (expected_walls.size() == 0) begin
        report($sformatf("wall bit %b returned with no read outstanding", got));
        return;
      end
      e = expected_walls.pop_front();
      reads_checked++;
      if (got !== e.wall)
        report($sformatf("read x=%0d y=%0d side=%s in %0dx%0d: got %b want %b",
                         e.req.x, e.req.y, e.req.dir.name(), width_reg,
                         height_reg, got, e.wall));
    endtask

    function int pending();
      return expected_walls.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       cfg_write  = 1'b0;
  logic       cfg_index  = mwbs_pkg::REG_WIDTH;
  logic [4:0] cfg_data   = '0;
  logic       push       = 1'b0;
  logic       mode       = mwbs_pkg::MODE_READ;
  logic [7:0] cell_x     = '0;
  logic [7:0] cell_y     = '0;
  logic [1:0] direction  = mwbs_pkg::DIR_NORTH;
  logic       wall_value = 1'b0;
  logic       pop        = 1'b0;
  logic       full;
  logic       empty;
  logic       wall_present;

  wall_map_checker sb = new;

  bit        steady = 1'b0;   // no idling on either side
  int        stall_cycles = 0;
  int        cur_w_lim;
  int        cur_h_lim;
  int        shapes_run = 0;
  bit        have_last = 1'b0;
  wall_req_t last_write;

  maze_wall_bitmap_store_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .direction   (direction),
    .wall_value  (wall_value),
    .empty       (empty),
    .pop         (pop),
    .wall_present(wall_present)
  );

  always #10 clk = ~clk;

  function automatic wall_req_t make_req(logic m, int x, int y,
                                         mwbs_pkg::dir_t d, logic v);
    wall_req_t r;
    r.mode  = m;
    r.x     = x[7:0];
    r.y     = y[7:0];
    r.dir   = d;
    r.value = v;
    return r;
  endfunction

  // leaves push high so back-to-back requests follow without a gap
  task send_request(wall_req_t r);
    while (!steady && $urandom_range(99) < 12) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    mode       <= r.mode;
    cell_x     <= r.x;
    cell_y     <= r.y;
    direction  <= r.dir;
    wall_value <= r.value;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(r);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_shape(int w, int h);
    cfg_write <= 1'b1;
    cfg_index <= mwbs_pkg::REG_WIDTH;
    cfg_data  <= 5'(w);
    @(posedge clk);
    sb.set_dim(mwbs_pkg::REG_WIDTH, 5'(w));
    cfg_index <= mwbs_pkg::REG_HEIGHT;
    cfg_data  <= 5'(h);
    @(posedge clk);
    sb.set_dim(mwbs_pkg::REG_HEIGHT, 5'(h));
    cfg_write <= 1'b0;
    cur_w_lim = (w > MAX_DIM) ? MAX_DIM : w;
    cur_h_lim = (h > MAX_DIM) ? MAX_DIM : h;
    have_last = 1'b0;
  endtask

  task random_request();
    wall_req_t r;
    r.mode  = ($urandom_range(99) < 40) ? mwbs_pkg::MODE_WRITE : mwbs_pkg::MODE_READ;
    r.value = 1'($urandom_range(1));
    r.dir   = mwbs_pkg::dir_t'($urandom_range(3));
    if ($urandom_range(99) < 10) begin
      r.x = 8'($urandom_range(255));
      r.y = 8'($urandom_range(255));
    end else if (r.mode == mwbs_pkg::MODE_READ && have_last && $urandom_range(99) < 45) begin
      // read back the last written wall, from either side of it
      r = last_write;
      r.mode = mwbs_pkg::MODE_READ;
      if ($urandom_range(1)) begin
        case (last_write.dir)
          mwbs_pkg::DIR_NORTH: begin
            r.y = last_write.y + 8'd1; r.dir = mwbs_pkg::DIR_SOUTH;
          end
          mwbs_pkg::DIR_SOUTH: begin
            r.y = last_write.y - 8'd1; r.dir = mwbs_pkg::DIR_NORTH;
          end
          mwbs_pkg::DIR_EAST: begin
            r.x = last_write.x + 8'd1; r.dir = mwbs_pkg::DIR_WEST;
          end
          default: begin
            r.x = last_write.x - 8'd1; r.dir = mwbs_pkg::DIR_EAST;
          end
        endcase
      end
    end else begin
      // one past the grid edge is included to hit the outside case
      r.x = 8'($urandom_range(cur_w_lim));
      r.y = 8'($urandom_range(cur_h_lim));
    end
    if (r.mode == mwbs_pkg::MODE_WRITE) begin
      last_write = r;
      have_last  = 1'b1;
    end
    send_request(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_wall(wall_present);
      pop <= steady || ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", stall_cycles);
        $display("[maze_wall_bitmap_store_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    cur_w_lim = MAX_DIM;
    cur_h_lim = MAX_DIM;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset dimensions 16x16
    send_request(make_req(mwbs_pkg::MODE_WRITE, 3, 4, mwbs_pkg::DIR_NORTH, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 3, 5, mwbs_pkg::DIR_SOUTH, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 3, 4, mwbs_pkg::DIR_NORTH, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 7, 2, mwbs_pkg::DIR_EAST, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 8, 2, mwbs_pkg::DIR_WEST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 8, 2, mwbs_pkg::DIR_WEST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 7, 2, mwbs_pkg::DIR_EAST, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 0, 0, mwbs_pkg::DIR_SOUTH, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 0, 0, mwbs_pkg::DIR_WEST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 15, 15, mwbs_pkg::DIR_NORTH, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 15, 15, mwbs_pkg::DIR_EAST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 15, 3, mwbs_pkg::DIR_EAST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 15, 3, mwbs_pkg::DIR_EAST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 255, 255, mwbs_pkg::DIR_NORTH, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 255, 0, mwbs_pkg::DIR_WEST, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 0, 255, mwbs_pkg::DIR_EAST, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 0, 0, mwbs_pkg::DIR_NORTH, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 0, 1, mwbs_pkg::DIR_SOUTH, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 14, 15, mwbs_pkg::DIR_EAST, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 15, 15, mwbs_pkg::DIR_WEST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_READ, 1, 1, mwbs_pkg::DIR_WEST, 1'b0));
    send_request(make_req(mwbs_pkg::MODE_WRITE, 255, 255, mwbs_pkg::DIR_SOUTH, 1'b1));
    send_request(make_req(mwbs_pkg::MODE_READ, 4, 15, mwbs_pkg::DIR_SOUTH, 1'b1));
    push <= 1'b0;
    wait_drained();

    for (int p = 0; p < N_SHAPES; p++) begin
      set_shape(SHAPE_W[p], SHAPE_H[p]);
      steady = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      push <= 1'b0;
      wait_drained();
      shapes_run++;
    end

    $display("covered %0d reads and %0d writes over %0d maze shapes",
             sb.reads_checked, sb.writes_seen, shapes_run + 1);
    $display("shapes include zero, one, oversize and non-square dimensions");
    if (sb.errors == 0) begin
      $display("[maze_wall_bitmap_store_core] OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[maze_wall_bitmap_store_core] ERROR");
    end
    $finish;
  end

endmodule
